### src/dcsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dcsr_pkg;

    // Lane geometry
    localparam int LANES  = 4;
    localparam int IDX_W  = $clog2(LANES);
    localparam int KEPT_W = 3;

    // Field widths
    localparam int CFG_W    = 17;
    localparam int COL_W    = 16;
    localparam int VAL_W    = 32;
    localparam int MASK_W   = 8;
    localparam int ROW_W    = 16;
    localparam int TOTAL_W  = 33;

    // Largest row length honored; larger register values are clamped to it
    localparam logic [32:0] MAX_COLS = 33'd65536;
    // Largest row count honored
    localparam logic [CFG_W-1:0] MAX_ROWS = 17'd65536;

    // Stream payload widths
    localparam int IN_TDATA_W  = LANES * (VAL_W + MASK_W);
    localparam int OUT_BITS    = KEPT_W + LANES * (COL_W + VAL_W) + TOTAL_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Configuration register indexes
    localparam logic CFG_COLS_PER_ROW = 1'b0;
    localparam logic CFG_ROW_COUNT    = 1'b1;

    // What one lane reports about its element
    typedef struct packed {
        logic             keep;
        logic [COL_W-1:0] column;
        logic [VAL_W-1:0] data;
    } lane_t;

    // Compacted slots of one item
    typedef struct packed {
        logic [LANES-1:0][VAL_W-1:0] data;
        logic [LANES-1:0][COL_W-1:0] column;
        logic [KEPT_W-1:0]           kept_count;
    } slots_t;

    // Full result of one item
    typedef struct packed {
        logic                 matrix_done;
        logic                 row_done;
        logic [TOTAL_W-1:0]   row_offset;
        slots_t               slots;
    } result_t;

endpackage

`default_nettype wire

### src/dcsr_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// One element: column of this lane and whether it is kept
module dcsr_lane #(
    parameter int LANE = 0
) (
    input  wire logic [dcsr_pkg::CFG_W-1:0]  col_base,
    input  wire logic [dcsr_pkg::CFG_W-1:0]  row_len,
    input  wire logic [dcsr_pkg::VAL_W-1:0]  value,
    input  wire logic [dcsr_pkg::MASK_W-1:0] mask,
    output dcsr_pkg::lane_t                  lane
);

    logic [dcsr_pkg::CFG_W:0] col;

    // Column of this lane, one bit wider so it never wraps
    always_comb
    begin
        col         = {1'b0, col_base} + (dcsr_pkg::CFG_W + 1)'(LANE);
        lane.keep   = (col < {1'b0, row_len}) && (mask != '0);
        lane.column = col[dcsr_pkg::COL_W-1:0];
        lane.data   = value;
    end

endmodule

`default_nettype wire

### src/dcsr_merge.sv
`timescale 1ns / 1ps
`default_nettype none

// Packs the kept lanes, in lane order, into the low slots
module dcsr_merge (
    input  wire dcsr_pkg::lane_t [dcsr_pkg::LANES-1:0] lanes,
    output dcsr_pkg::slots_t                           slots
);

    logic [dcsr_pkg::KEPT_W-1:0] cnt;

    // Running count of kept lanes picks each lane's slot
    always_comb
    begin
        cnt   = '0;
        slots = '0;
        for (int l = 0; l < dcsr_pkg::LANES; l++)
        begin
            if (lanes[l].keep)
            begin
                slots.column[cnt[dcsr_pkg::IDX_W-1:0]] = lanes[l].column;
                slots.data[cnt[dcsr_pkg::IDX_W-1:0]]   = lanes[l].data;
                cnt = cnt + 1'b1;
            end
        end
        slots.kept_count = cnt;
    end

endmodule

`default_nettype wire

### src/dcsr_obuf.sv
`timescale 1ns / 1ps
`default_nettype none

// Output register with one skid entry; upstream ready is registered
module dcsr_obuf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire dcsr_pkg::result_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dcsr_pkg::result_t      out_data
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    dcsr_pkg::result_t out_data_reg, out_data_next;
    dcsr_pkg::result_t skid_data_reg, skid_data_next;
    logic              take;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign take      = in_valid && in_ready;

    // Refill the output register from skid first, then from a new request
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (take)
            begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (take)
        begin
            skid_data_next  = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

`ifndef NO_ASSERTIONS
    // Skid entry is only used behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    // A stalled result with a request behind it fills the skid entry
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && take) |=> skid_valid_reg)
        else $error("request lost while output stalled");
`endif

endmodule

`default_nettype wire

### src/masked_dense_to_csr_compactor_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Signals                         | Moves
// ----------+---------------------------------+------------------------------------
// s_        | s_tvalid s_tready s_tdata       | LANES values and mask bytes
// m_        | m_tvalid m_tready m_tdata       | compacted slots, row offset
//           | m_tlast m_tuser                 | row end, matrix end
// cfg_      | cfg_valid cfg_ready cfg_index   | register writes (always ready)
//           | cfg_data                        |
//
// One item is accepted every cycle while s_tready is high; m_ is driven from a register.
// Lane compare and compaction plus the running total sit before one output register.
// A skid entry behind the output register holds a result accepted while m_ stalls;
// s_tready falls after two results wait unread.
// Reset clears row, column and total; cols_per_row and row_count reset to 1.
// A register write takes effect for the next accepted item.
module masked_dense_to_csr_compactor_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // value_lane0..3 (32b each), then mask_lane0..3 (8b each)
    input  wire logic [dcsr_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // kept_count, column_slot0..3, data_slot0..3, row_offset, zero pad
    output logic [dcsr_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic                                   m_tlast,
    // matrix_done
    output logic                                   m_tuser,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic                              cfg_index,
    input  wire logic [dcsr_pkg::CFG_W-1:0]        cfg_data
);

    logic [dcsr_pkg::CFG_W-1:0]   cols_cfg_reg, rows_cfg_reg;
    logic [dcsr_pkg::CFG_W-1:0]   col_pos_reg, col_pos_next;
    logic [dcsr_pkg::ROW_W-1:0]   row_pos_reg, row_pos_next;
    logic [dcsr_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [dcsr_pkg::CFG_W-1:0]   row_len, row_cnt;
    logic [dcsr_pkg::CFG_W:0]     col_end;
    logic [dcsr_pkg::CFG_W-1:0]   row_inc;
    logic [dcsr_pkg::TOTAL_W-1:0] total_sum;
    logic                         row_end, mat_end, accept;

    dcsr_pkg::lane_t [dcsr_pkg::LANES-1:0] lanes;
    dcsr_pkg::slots_t                      slots;
    dcsr_pkg::result_t                     res, res_out;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= 17'd1;
            rows_cfg_reg <= 17'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dcsr_pkg::CFG_COLS_PER_ROW: cols_cfg_reg <= cfg_data;
                dcsr_pkg::CFG_ROW_COUNT:    rows_cfg_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Clamp register values to their honored ranges
    always_comb
    begin
        if (cols_cfg_reg == '0)
            row_len = 17'd1;
        else if ({16'd0, cols_cfg_reg} > dcsr_pkg::MAX_COLS)
            row_len = dcsr_pkg::MAX_COLS[dcsr_pkg::CFG_W-1:0];
        else
            row_len = cols_cfg_reg;

        if (rows_cfg_reg == '0)
            row_cnt = 17'd1;
        else if (rows_cfg_reg > dcsr_pkg::MAX_ROWS)
            row_cnt = dcsr_pkg::MAX_ROWS;
        else
            row_cnt = rows_cfg_reg;
    end

    // Lanes
    for (genvar g = 0; g < dcsr_pkg::LANES; g++)
    begin : g_lane
        dcsr_lane #(
            .LANE (g)
        ) u_lane (
            .col_base (col_pos_reg),
            .row_len  (row_len),
            .value    (s_tdata[g*dcsr_pkg::VAL_W +: dcsr_pkg::VAL_W]),
            .mask     (s_tdata[dcsr_pkg::LANES*dcsr_pkg::VAL_W + g*dcsr_pkg::MASK_W
                               +: dcsr_pkg::MASK_W]),
            .lane     (lanes[g])
        );
    end

    dcsr_merge u_merge (
        .lanes (lanes),
        .slots (slots)
    );

    // Row and matrix end, running total
    always_comb
    begin
        col_end   = {1'b0, col_pos_reg} + (dcsr_pkg::CFG_W + 1)'(dcsr_pkg::LANES);
        row_inc   = {1'b0, row_pos_reg} + 17'd1;
        row_end   = col_end >= {1'b0, row_len};
        mat_end   = row_end && (row_inc >= row_cnt);
        total_sum = total_reg + dcsr_pkg::TOTAL_W'(slots.kept_count);

        res.slots       = slots;
        res.row_done    = row_end;
        res.matrix_done = mat_end;
        res.row_offset  = row_end ? total_sum : '0;

        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        total_next   = total_reg;
        if (accept)
        begin
            if (mat_end)
            begin
                col_pos_next = '0;
                row_pos_next = '0;
                total_next   = '0;
            end
            else if (row_end)
            begin
                col_pos_next = '0;
                row_pos_next = row_inc[dcsr_pkg::ROW_W-1:0];
                total_next   = total_sum;
            end
            else
            begin
                col_pos_next = col_end[dcsr_pkg::CFG_W-1:0];
                total_next   = total_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            total_reg   <= '0;
        end
        else
        begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            total_reg   <= total_next;
        end
    end

    dcsr_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_out)
    );

    // Stream packing
    assign m_tdata = {(dcsr_pkg::OUT_TDATA_W - dcsr_pkg::OUT_BITS)'(0),
                      res_out.row_offset, res_out.slots};
    assign m_tlast = res_out.row_done;
    assign m_tuser = res_out.matrix_done;

`ifndef NO_ASSERTIONS
    // Compaction keeps exactly the lanes that pass
    a_kept_count: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid |-> (32'(slots.kept_count) == $countones({lanes[3].keep, lanes[2].keep,
                                                           lanes[1].keep, lanes[0].keep})))
        else $error("kept_count differs from kept lanes");

    // End of matrix returns all position state to zero
    a_matrix_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mat_end) |=> (col_pos_reg == '0 && row_pos_reg == '0 && total_reg == '0))
        else $error("state not cleared after matrix end");
`endif

endmodule

`default_nettype wire

### verif/csr_result_checker.sv
`timescale 1ns / 1ps

module csr_result_checker
    import dcsr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic                   m_tlast,
    input  wire logic                   m_tuser,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic                   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    output int                          mismatches,
    output int                          pending
);

    // Shadow copy of the registers and the row walk
    logic [CFG_W-1:0]   cols_reg;
    logic [CFG_W-1:0]   rows_reg;
    logic [16:0]        col_pos;
    logic [ROW_W-1:0]   row_pos;
    logic [TOTAL_W-1:0] nz_total;

    result_t expected_rows[$];
    result_t want;
    result_t seen;
    int      err_count;

    // Compacts one chunk and advances the row walk
    function automatic result_t compact_chunk(input logic [IN_TDATA_W-1:0] chunk);
        result_t     r;
        logic [32:0] k;
        logic [32:0] m;
        logic [32:0] col;
        int          kept;
        r    = '0;
        kept = 0;
        k = {16'd0, cols_reg};
        if (k == 0) k = 33'd1;
        if (k > MAX_COLS) k = MAX_COLS;
        m = {16'd0, rows_reg};
        if (m == 0) m = 33'd1;
        if (m > {16'd0, MAX_ROWS}) m = {16'd0, MAX_ROWS};
        for (int lane = 0; lane < LANES; lane++) begin
            col = {16'd0, col_pos} + 33'(lane);
            if (col < k && chunk[LANES*VAL_W + lane*MASK_W +: MASK_W] != '0) begin
                r.slots.column[kept] = col[COL_W-1:0];
                r.slots.data[kept]   = chunk[lane*VAL_W +: VAL_W];
                kept++;
            end
        end
        r.slots.kept_count = KEPT_W'(kept);
        nz_total = nz_total + TOTAL_W'(kept);
        // row end: last lane reaches or passes the row length
        if ({16'd0, col_pos} + 33'(LANES) >= k) begin
            r.row_done   = 1'b1;
            r.row_offset = nz_total;
            col_pos      = '0;
            if ({17'd0, row_pos} + 33'd1 >= m) begin
                r.matrix_done = 1'b1;
                row_pos       = '0;
                nz_total      = '0;
            end
            else begin
                row_pos = row_pos + 1'b1;
            end
        end
        else begin
            col_pos = col_pos + 17'(LANES);
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            err_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cols_reg  = 17'd1;
            rows_reg  = 17'd1;
            col_pos   = '0;
            row_pos   = '0;
            nz_total  = '0;
            err_count = 0;
            expected_rows.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else begin
            // result side first, so a stray result is never matched to a new request
            if (m_tvalid && m_tready) begin
                if (expected_rows.size() == 0) begin
                    $error("result arrived with no request pending");
                    err_count++;
                end
                else begin
                    want = expected_rows.pop_front();
                    seen = result_t'({m_tuser, m_tlast, m_tdata[OUT_BITS-1:0]});
                    check_field("kept_count", 64'(want.slots.kept_count),
                                64'(seen.slots.kept_count));
                    for (int i = 0; i < LANES; i++) begin
                        check_field($sformatf("column_slot%0d", i),
                                    64'(want.slots.column[i]), 64'(seen.slots.column[i]));
                        check_field($sformatf("data_slot%0d", i),
                                    64'(want.slots.data[i]), 64'(seen.slots.data[i]));
                    end
                    check_field("row_done", 64'(want.row_done), 64'(seen.row_done));
                    check_field("row_offset", 64'(want.row_offset), 64'(seen.row_offset));
                    check_field("matrix_done", 64'(want.matrix_done),
                                64'(seen.matrix_done));
                end
            end
            if (s_tvalid && s_tready) begin
                expected_rows.push_back(compact_chunk(s_tdata));
            end
            // register writes apply from the next request on
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_COLS_PER_ROW) cols_reg = cfg_data;
                else rows_reg = cfg_data;
            end
            mismatches <= err_count;
            pending    <= expected_rows.size();
        end
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dcsr_pkg::*;

    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic                   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    int mismatches;
    int pending;
    int send_idle_pct = 35;
    int recv_idle_pct = 61;
    int cycle_count   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    masked_dense_to_csr_compactor_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    csr_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Receiver back-pressure, held low during reset
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [IN_TDATA_W-1:0] pack_chunk(
        input logic [LANES-1:0][VAL_W-1:0]  vals,
        input logic [LANES-1:0][MASK_W-1:0] masks);
        return {masks, vals};
    endfunction

    // Random chunk: empty, dense or mixed masks, occasional edge values
    function automatic logic [IN_TDATA_W-1:0] random_chunk();
        logic [LANES-1:0][VAL_W-1:0]  vals;
        logic [LANES-1:0][MASK_W-1:0] masks;
        int                           mode;
        mode = $urandom_range(4);
        for (int i = 0; i < LANES; i++)
        begin
            case ($urandom_range(9))
                0:       vals[i] = '0;
                1:       vals[i] = '1;
                default: vals[i] = $urandom;
            endcase
            if (mode == 0) masks[i] = '0;
            else if (mode == 1) masks[i] = MASK_W'($urandom_range(1, 255));
            else masks[i] = $urandom_range(1) ? MASK_W'($urandom) : '0;
        end
        return pack_chunk(vals, masks);
    endfunction

    // One request on the input stream, with random idle cycles ahead of it
    task automatic send_chunk(input logic [IN_TDATA_W-1:0] chunk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= chunk;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Register write once the block has drained
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) send_chunk(random_chunk());
    endtask

    initial
    begin
        logic [LANES-1:0][VAL_W-1:0]  vals;
        logic [LANES-1:0][MASK_W-1:0] masks;
        logic [CFG_W-1:0]             cols;
        logic [CFG_W-1:0]             rows;
        int                           eff_k;
        int                           eff_m;
        int                           full_items;
        int                           count;
        int                           items_sent;

        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_COLS_PER_ROW;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: one column, one row, only lane 0 counts
        vals  = {LANES{32'hFFFF_FFFF}};
        masks = {LANES{8'hFF}};
        send_chunk(pack_chunk(vals, masks));

        // Zero registers act as one
        write_reg(CFG_COLS_PER_ROW, 17'd0);
        write_reg(CFG_ROW_COUNT, 17'd0);
        vals  = '0;
        masks = {8'h00, 8'h00, 8'h00, 8'h01};
        send_chunk(pack_chunk(vals, masks));

        // Two rows of six columns: partial last chunk, mixed masks
        write_reg(CFG_COLS_PER_ROW, 17'd6);
        write_reg(CFG_ROW_COUNT, 17'd2);
        vals  = {32'h7FC0_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
        masks = {8'hFF, 8'h00, 8'h80, 8'h01};
        send_chunk(pack_chunk(vals, masks));
        masks = {LANES{8'hFF}};
        send_chunk(pack_chunk(vals, masks));
        masks = {8'h01, 8'h80, 8'h00, 8'hFF};
        send_chunk(pack_chunk(vals, masks));
        masks = '0;
        send_chunk(pack_chunk(vals, masks));

        // Shrink the row under the current column: the chunk is dropped and ends the row
        write_reg(CFG_COLS_PER_ROW, 17'd7);
        write_reg(CFG_ROW_COUNT, 17'd3);
        send_random(1);
        write_reg(CFG_COLS_PER_ROW, 17'd3);
        masks = {LANES{8'hFF}};
        send_chunk(pack_chunk(vals, masks));
        // Shrink the matrix under the current row: next row end is the matrix end
        write_reg(CFG_ROW_COUNT, 17'd1);
        send_chunk(pack_chunk(vals, masks));

        // Oversized registers clamp, then exact maximum
        write_reg(CFG_COLS_PER_ROW, 17'h1FFFF);
        write_reg(CFG_ROW_COUNT, 17'h1FFFF);
        send_random(3);
        write_reg(CFG_COLS_PER_ROW, 17'd65536);
        write_reg(CFG_ROW_COUNT, 17'd65536);
        send_random(2);
        write_reg(CFG_COLS_PER_ROW, 17'd4);
        write_reg(CFG_ROW_COUNT, 17'd1);
        send_random(2);

        // Single-column rows
        write_reg(CFG_COLS_PER_ROW, 17'd1);
        write_reg(CFG_ROW_COUNT, 17'd4);
        send_random(4);

        // Random matrices across the three idle profiles
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (items_sent >= RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 35;
            end
            case ($urandom_range(11))
                0:       cols = 17'd0;
                1:       cols = 17'd65536;
                2:       cols = 17'($urandom_range(65537, 131071));
                3:       cols = 17'($urandom);
                default: cols = 17'($urandom_range(1, 40));
            endcase
            case ($urandom_range(9))
                0:       rows = 17'd0;
                1:       rows = 17'($urandom);
                2:       rows = 17'h1FFFF;
                default: rows = 17'($urandom_range(1, 6));
            endcase
            write_reg(CFG_COLS_PER_ROW, cols);
            write_reg(CFG_ROW_COUNT, rows);
            eff_k = (cols == 0) ? 1 : ((cols > 65536) ? 65536 : int'(cols));
            eff_m = (rows == 0) ? 1 : ((rows > 65536) ? 65536 : int'(rows));
            full_items = ((eff_k + LANES - 1) / LANES) * eff_m;
            // whole matrices capped at 48 items; some cut short so the next write lands mid-matrix
            if ($urandom_range(3) == 0) count = $urandom_range(1, 12);
            else count = full_items;
            if (count > 48) count = 48;
            send_random(count);
            items_sent += count;
        end

        // Drain
        s_tvalid <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
